### rtl/brle8_pkg.sv
`default_nettype none

package brle8_pkg;

  localparam int COORD_BITS  = 16;
  localparam int BYTE_BITS   = 8;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam logic [COORD_BITS-1:0] IMAGE_WIDTH_RST = COORD_BITS'(640);

  typedef enum logic [1:0] {
    KIND_FILL = 2'd0,
    KIND_RUN  = 2'd1,
    KIND_DONE = 2'd2,
    KIND_ERR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_CMD0 = 3'd0,
    PH_CMD1 = 3'd1,
    PH_DX   = 3'd2,
    PH_DY   = 3'd3,
    PH_LIT  = 3'd4,
    PH_PAD  = 3'd5,
    PH_DONE = 3'd6
  } phase_t;

  localparam logic [BYTE_BITS-1:0] ESC_EOL   = 8'd0;
  localparam logic [BYTE_BITS-1:0] ESC_EOB   = 8'd1;
  localparam logic [BYTE_BITS-1:0] ESC_DELTA = 8'd2;

  typedef struct packed {
    kind_t                 kind;
    logic [COORD_BITS-1:0] start_x;
    logic [COORD_BITS-1:0] start_y;
    logic [COORD_BITS-1:0] end_x;
    logic [COORD_BITS-1:0] end_y;
    logic [BYTE_BITS-1:0]  color_index;
    logic [BYTE_BITS-1:0]  run_length;
    logic                  last_of_item;
  } res_t;

  function automatic logic [COORD_BITS-1:0] sat_add(input logic [COORD_BITS-1:0] a,
                                                    input logic [BYTE_BITS-1:0] b);
    logic [COORD_BITS:0] s;
    s = {1'b0, a} + {{(COORD_BITS + 1 - BYTE_BITS){1'b0}}, b};
    return s[COORD_BITS] ? {COORD_BITS{1'b1}} : s[COORD_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

### rtl/brle8_out_fifo.sv
`default_nettype none

module brle8_out_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [1:0]       push_n,
  input  wire brle8_pkg::res_t  push0,
  input  wire brle8_pkg::res_t  push1,
  output logic                  space_low,
  output logic                  head_valid,
  input  wire logic             head_stall,
  output brle8_pkg::res_t       head
);
  import brle8_pkg::*;

  res_t                entries [FIFO_DEPTH];
  logic [FIFO_AW-1:0]  wr_ptr;
  logic [FIFO_AW-1:0]  rd_ptr;
  logic [FIFO_AW:0]    count;
  logic                pop;

  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign pop        = head_valid && !head_stall;
  assign space_low  = (count > (FIFO_AW + 1)'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      entries[wr_ptr] <= push0;
    end
    if (push_n == 2'd2) begin
      entries[FIFO_AW'(wr_ptr + 1'b1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= FIFO_AW'(wr_ptr + push_n);
      if (pop) begin
        rd_ptr <= FIFO_AW'(rd_ptr + 1'b1);
      end
      count <= (FIFO_AW + 1)'(count + {{(FIFO_AW - 1){1'b0}}, push_n} - {{FIFO_AW{1'b0}}, pop});
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (FIFO_AW + 1)'(FIFO_DEPTH))
    else $error("result queue over depth");

  a_push_fits: assert property (@(posedge clk) disable iff (rst)
    (push_n != 2'd0) |-> !space_low)
    else $error("push while queue low on space");

  a_push_range: assert property (@(posedge clk) disable iff (rst)
    push_n != 2'd3)
    else $error("more than two results pushed");

  a_head_holds: assert property (@(posedge clk) disable iff (rst)
    (head_valid && head_stall) |=> (head_valid && $stable(rd_ptr)))
    else $error("stalled head lost");
`endif

endmodule

`default_nettype wire

### rtl/bmp_rle8_span_decoder_core.sv
// Span decoder for an 8-bit run-length bitmap stream.
// Input channel: one compressed byte per word (data_byte), or an end-of-file
// marker (end_of_data). A word moves when in_valid is high and in_stall low.
// Output channel: one span result per word, moved when out_valid is high and
// out_stall low. Each input word yields zero, one or two results (a gap fill
// before a color run, or a fill before bitmap done); last_of_item marks the
// final result of an input word.
// Results are registered in the result queue and leave from its head.
// Throughput: one input word per cycle while each word yields at most one
// result and the receiver does not stall; a four-entry result queue absorbs the
// second result of a word, and in_stall rises while fewer than two entries are free.
// When the receiver stalls, the head result holds and the queue fills; input
// then stalls too.
// image_width is written via cfg_wr_en / cfg_wr_data by the user only while idle; the block leaves it unchecked.
// Reset (rst, synchronous) empties the queue, sets image_width to 640, the
// position to the top-left corner and waits for a command byte. After bitmap
// done or a truncation error all further input words are dropped when taken.
`default_nettype none

module bmp_rle8_span_decoder_core (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [brle8_pkg::COORD_BITS-1:0] cfg_wr_data,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [brle8_pkg::BYTE_BITS-1:0]  data_byte,
  input  wire logic                            end_of_data,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [1:0]                           kind,
  output logic [brle8_pkg::COORD_BITS-1:0]      start_x,
  output logic [brle8_pkg::COORD_BITS-1:0]      start_y,
  output logic [brle8_pkg::COORD_BITS-1:0]      end_x,
  output logic [brle8_pkg::COORD_BITS-1:0]      end_y,
  output logic [brle8_pkg::BYTE_BITS-1:0]       color_index,
  output logic [brle8_pkg::BYTE_BITS-1:0]       run_length,
  output logic                                 last_of_item
);
  import brle8_pkg::*;

  logic [COORD_BITS-1:0]        image_width;
  phase_t                       phase, phase_next;
  logic [BYTE_BITS-1:0]         first_byte, first_byte_next;
  logic [BYTE_BITS-1:0]         delta_dx, delta_dx_next;
  logic [BYTE_BITS-1:0]         literal_left, literal_left_next;
  logic                         pad_pending, pad_pending_next;
  logic [COORD_BITS-1:0]        cur_x, cur_x_next;
  logic [COORD_BITS-1:0]        cur_y, cur_y_next;
  logic signed [COORD_BITS:0]   last_written_x, last_written_x_next;
  logic [COORD_BITS-1:0]        last_written_y, last_written_y_next;

  logic                         accept;
  logic signed [COORD_BITS+1:0] lwx_p1;
  logic [COORD_BITS-1:0]        fill_sx;
  logic                         gap;
  logic                         eob_fill;
  logic [BYTE_BITS-1:0]         span_len;
  logic [COORD_BITS:0]          span_end;
  logic [COORD_BITS-1:0]        span_end_sat;
  res_t                         fill_rec, run_rec, eob_rec, done_rec, err_rec;
  res_t                         r0, r1;
  logic [1:0]                   n_res;
  logic [1:0]                   push_n;
  logic                         space_low;
  res_t                         head;

  assign accept = in_valid && !in_stall;
  assign in_stall = space_low;

  assign lwx_p1  = {last_written_x[COORD_BITS], last_written_x} + (COORD_BITS + 2)'(1);
  assign fill_sx = lwx_p1[COORD_BITS] ? {COORD_BITS{1'b1}} : lwx_p1[COORD_BITS-1:0];
  assign gap     = (cur_y > last_written_y) ||
                   ((cur_y == last_written_y) && ($signed({2'b00, cur_x}) > lwx_p1));
  assign eob_fill = lwx_p1 < $signed({2'b00, image_width});

  assign span_len     = (phase == PH_LIT) ? BYTE_BITS'(1) : first_byte;
  assign span_end     = {1'b0, cur_x} + {{(COORD_BITS + 1 - BYTE_BITS){1'b0}}, span_len}
                        - (COORD_BITS + 1)'(1);
  assign span_end_sat = span_end[COORD_BITS] ? {COORD_BITS{1'b1}} : span_end[COORD_BITS-1:0];

  always_comb begin
    fill_rec = '{kind: KIND_FILL, start_x: fill_sx, start_y: last_written_y,
                 end_x: cur_x, end_y: cur_y, color_index: '0, run_length: '0,
                 last_of_item: 1'b0};
    run_rec  = '{kind: KIND_RUN, start_x: cur_x, start_y: cur_y, end_x: '0, end_y: '0,
                 color_index: data_byte, run_length: span_len, last_of_item: 1'b1};
    eob_rec  = '{kind: KIND_FILL, start_x: fill_sx, start_y: last_written_y,
                 end_x: image_width, end_y: last_written_y, color_index: '0,
                 run_length: '0, last_of_item: 1'b0};
    done_rec = '{kind: KIND_DONE, start_x: '0, start_y: '0, end_x: '0, end_y: '0,
                 color_index: '0, run_length: '0, last_of_item: 1'b1};
    err_rec  = '{kind: KIND_ERR, start_x: '0, start_y: '0, end_x: '0, end_y: '0,
                 color_index: '0, run_length: '0, last_of_item: 1'b1};
  end

  always_comb begin
    phase_next          = phase;
    first_byte_next     = first_byte;
    delta_dx_next       = delta_dx;
    literal_left_next   = literal_left;
    pad_pending_next    = pad_pending;
    cur_x_next          = cur_x;
    cur_y_next          = cur_y;
    last_written_x_next = last_written_x;
    last_written_y_next = last_written_y;
    r0                  = err_rec;
    r1                  = done_rec;
    n_res               = 2'd0;

    if (phase == PH_DONE) begin
      n_res = 2'd0;
    end else if (end_of_data) begin
      r0         = err_rec;
      n_res      = 2'd1;
      phase_next = PH_DONE;
    end else begin
      unique case (phase)
        PH_CMD0: begin
          first_byte_next = data_byte;
          phase_next      = PH_CMD1;
        end
        PH_CMD1: begin
          phase_next = PH_CMD0;
          if (first_byte != '0) begin
            if (gap) begin
              r0    = fill_rec;
              r1    = run_rec;
              n_res = 2'd2;
            end else begin
              r0    = run_rec;
              n_res = 2'd1;
            end
            last_written_x_next = $signed({1'b0, span_end_sat});
            last_written_y_next = cur_y;
            cur_x_next          = sat_add(cur_x, first_byte);
          end else if (data_byte == ESC_EOL) begin
            cur_x_next = '0;
            cur_y_next = sat_add(cur_y, BYTE_BITS'(1));
          end else if (data_byte == ESC_EOB) begin
            if (eob_fill) begin
              r0    = eob_rec;
              r1    = done_rec;
              n_res = 2'd2;
            end else begin
              r0    = done_rec;
              n_res = 2'd1;
            end
            last_written_x_next = '1;
            last_written_y_next = sat_add(last_written_y, BYTE_BITS'(1));
            phase_next          = PH_DONE;
          end else if (data_byte == ESC_DELTA) begin
            phase_next = PH_DX;
          end else begin
            literal_left_next = data_byte;
            pad_pending_next  = data_byte[0];
            phase_next        = PH_LIT;
          end
        end
        PH_DX: begin
          delta_dx_next = data_byte;
          phase_next    = PH_DY;
        end
        PH_DY: begin
          cur_x_next = sat_add(cur_x, delta_dx);
          cur_y_next = sat_add(cur_y, data_byte);
          phase_next = PH_CMD0;
        end
        PH_LIT: begin
          if (gap) begin
            r0    = fill_rec;
            r1    = run_rec;
            n_res = 2'd2;
          end else begin
            r0    = run_rec;
            n_res = 2'd1;
          end
          last_written_x_next = $signed({1'b0, span_end_sat});
          last_written_y_next = cur_y;
          cur_x_next          = sat_add(cur_x, BYTE_BITS'(1));
          literal_left_next   = BYTE_BITS'(literal_left - 1'b1);
          if (literal_left_next == '0) begin
            phase_next       = pad_pending ? PH_PAD : PH_CMD0;
            pad_pending_next = 1'b0;
          end
        end
        PH_PAD: begin
          pad_pending_next = 1'b0;
          phase_next       = PH_CMD0;
        end
        default: begin
          phase_next = PH_CMD0;
        end
      endcase
    end
  end

  assign push_n = accept ? n_res : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width    <= IMAGE_WIDTH_RST;
      phase          <= PH_CMD0;
      first_byte     <= '0;
      delta_dx       <= '0;
      literal_left   <= '0;
      pad_pending    <= 1'b0;
      cur_x          <= '0;
      cur_y          <= '0;
      last_written_x <= '1;
      last_written_y <= '0;
    end else begin
      if (cfg_wr_en) begin
        image_width <= cfg_wr_data;
      end
      if (accept) begin
        phase          <= phase_next;
        first_byte     <= first_byte_next;
        delta_dx       <= delta_dx_next;
        literal_left   <= literal_left_next;
        pad_pending    <= pad_pending_next;
        cur_x          <= cur_x_next;
        cur_y          <= cur_y_next;
        last_written_x <= last_written_x_next;
        last_written_y <= last_written_y_next;
      end
    end
  end

  brle8_out_fifo u_out_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_n     (push_n),
    .push0      (r0),
    .push1      (r1),
    .space_low  (space_low),
    .head_valid (out_valid),
    .head_stall (out_stall),
    .head       (head)
  );

  assign kind         = head.kind;
  assign start_x      = head.start_x;
  assign start_y      = head.start_y;
  assign end_x        = head.end_x;
  assign end_y        = head.end_y;
  assign color_index  = head.color_index;
  assign run_length   = head.run_length;
  assign last_of_item = head.last_of_item;

`ifndef SYNTHESIS
  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DONE) |=> (phase == PH_DONE))
    else $error("left done phase");

  a_done_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && (phase == PH_DONE)) |-> (push_n == 2'd0))
    else $error("result after done");

  a_eof_ends: assert property (@(posedge clk) disable iff (rst)
    (accept && end_of_data) |=> (phase == PH_DONE))
    else $error("end of data did not stop decode");

  a_lwx_floor: assert property (@(posedge clk) disable iff (rst)
    last_written_x >= $signed({(COORD_BITS + 1){1'b1}}))
    else $error("last written column below minus one");
`endif

endmodule

`default_nettype wire
